/* design/bfha_pkg.sv */
// Shared types and codes for the best-fit heap allocator.
// No dependencies.
package bfha_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_A_DECIDE,
      ST_SHUP,
      ST_INS_WR,
      ST_F_MARK,
      ST_F_PREV_CHK,
      ST_F_NEXT_RD,
      ST_F_NEXT_CHK,
      ST_SHDN,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EXHAUSTED = 2'd1,
      STS_TABLE_FULL = 2'd2,
      STS_BAD_FREE  = 2'd3
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_HEADER_BYTES = 1'b0;
   localparam logic CSR_HEAP_LIMIT   = 1'b1;

   localparam logic [6:0]  HEADER_RESET = 7'd32;
   localparam logic [20:0] LIMIT_RESET  = 21'h100000;

endpackage

/* design/bfha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfha_ram #(
   parameter int WIDTH = 41,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/best_fit_heap_allocator_unit.sv */
// Top level of the best-fit heap allocator: control sequencer and segment table.
// Depends on bfha_pkg and bfha_ram.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  operation, request_size, payload_address
//   rsp_*        out   rsp_valid/rsp_stall  granted_address, status
//   csr_*        in    csr_write            csr_index, csr_wdata
//
// One word at a time. A word takes a table scan over the live segments, one RAM read per
// cycle, stopping early on a hit, then a table shift on each insert or merge, and decode
// and write-back, all through the single read port of the segment RAM.
// Reset is synchronous and needs no table clearing; the table starts empty.
// A finished result waits in the output register while the next word is taken.
module best_fit_heap_allocator_unit #(
   parameter int SEGMENTS  = 64,
   parameter int ADDR_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [19:0] req_request_size,
   input  logic [19:0] req_payload_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [19:0] rsp_granted_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata
);

   localparam int IW = $clog2(SEGMENTS);
   localparam int CW = $clog2(SEGMENTS + 1);
   localparam int AB = ADDR_BITS;
   localparam int EW = 2 * AB + 1;
   localparam int LW = ((AB > 21) ? AB : 21) + 3;

   localparam logic [LW-1:0] MASK_W = LW'((64'd1 << AB) - 64'd1);
   localparam logic [LW-1:0] CAP_W  = LW'(64'd1 << AB);

   bfha_pkg::state_type state_ff, state_in;

   logic [6:0]    header_ff, header_in;
   logic [20:0]   limit_ff, limit_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AB:0]   break_ff, break_in;

   logic          op_ff, op_in;
   logic [LW-1:0] reqsz_ff, reqsz_in;
   logic [LW-1:0] addr_ff, addr_in;

   logic [CW-1:0] issue_ff, issue_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;

   logic          best_vld_ff, best_vld_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [AB-1:0] best_start_ff, best_start_in;
   logic [AB-1:0] best_size_ff, best_size_in;

   logic [IW-1:0] cur_idx_ff, cur_idx_in;
   logic [AB-1:0] cur_start_ff, cur_start_in;
   logic [AB-1:0] cur_size_ff, cur_size_in;

   logic [CW-1:0] pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [EW-1:0] new_ff, new_in;
   logic          ret_next_ff, ret_next_in;

   logic [19:0]   res_grant_ff, res_grant_in;
   logic [1:0]    res_status_ff, res_status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [19:0]   rsp_grant_ff, rsp_grant_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [IW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;

   bfha_ram #(.WIDTH(EW), .DEPTH(SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // read-back fields
   logic [AB-1:0] rd_start, rd_size;
   logic          rd_free;
   logic [LW-1:0] hw, rd_start_w, rd_size_w, best_size_w, best_start_w;
   logic [LW-1:0] cur_end_w, lim_w, nb_w, bh_w, keep_w, tail_w;
   logic          accept, cand, exact, better, fhit, scan_stop, scan_end;
   logic          split, grow_bad, full, prev_merge, next_merge, shup_done, shdn_done;
   logic          rsp_free;

   assign rd_start     = ram_rdata[AB-1:0];
   assign rd_size      = ram_rdata[2*AB-1:AB];
   assign rd_free      = ram_rdata[2*AB];
   assign hw           = LW'(header_ff);
   assign rd_start_w   = LW'(rd_start);
   assign rd_size_w    = LW'(rd_size);
   assign best_size_w  = LW'(best_size_ff);
   assign best_start_w = LW'(best_start_ff);
   assign cur_end_w    = LW'(cur_start_ff) + hw + LW'(cur_size_ff);

   assign accept    = (state_ff == bfha_pkg::ST_IDLE) && req_valid;
   assign cand      = rd_free && (rd_size_w >= reqsz_ff);
   assign exact     = cand && (rd_size_w == reqsz_ff);
   assign better    = cand && (!best_vld_ff || (rd_size < best_size_ff));
   assign fhit      = !rd_free && ((rd_start_w + hw) == addr_ff);
   assign scan_stop = chk_vld_ff && ((op_ff == bfha_pkg::OP_ALLOC) ? exact : fhit);
   assign scan_end  = scan_stop || ((issue_ff == count_ff) && !chk_vld_ff);

   assign lim_w    = (LW'(limit_ff) > CAP_W) ? CAP_W : LW'(limit_ff);
   assign bh_w     = LW'(break_ff) + hw;
   assign nb_w     = bh_w + reqsz_ff;
   assign grow_bad = (nb_w > lim_w) || (bh_w > MASK_W);
   assign full     = (count_ff >= CW'(SEGMENTS));
   assign split    = best_size_w > (hw + reqsz_ff);
   assign keep_w   = best_size_w - reqsz_ff - hw;
   assign tail_w   = best_start_w + hw + keep_w;

   // prev entry sits before cur; next entry sits after cur
   assign prev_merge = rd_free && ((rd_start_w + hw + rd_size_w) == LW'(cur_start_ff));
   assign next_merge = rd_free && (cur_end_w == rd_start_w);
   assign shup_done  = (issue_ff == pos_ff) && !pend_ff;
   assign shdn_done  = (issue_ff == count_ff) && !pend_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfha_pkg::ST_IDLE: begin
            if (req_valid) begin
               if ((req_operation == bfha_pkg::OP_FREE)
                   && ((LW'(req_payload_address) & MASK_W) == '0)) begin
                  state_in = bfha_pkg::ST_RESP;
               end else begin
                  state_in = bfha_pkg::ST_SCAN;
               end
            end
         end
         bfha_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (op_ff == bfha_pkg::OP_ALLOC) begin
                  state_in = bfha_pkg::ST_A_DECIDE;
               end else if (scan_stop) begin
                  state_in = bfha_pkg::ST_F_MARK;
               end else begin
                  state_in = bfha_pkg::ST_RESP;
               end
            end
         end
         bfha_pkg::ST_A_DECIDE: begin
            if (best_vld_ff) begin
               if (split && !full) begin
                  state_in = bfha_pkg::ST_SHUP;
               end else begin
                  state_in = bfha_pkg::ST_RESP;
               end
            end else if (grow_bad || full) begin
               state_in = bfha_pkg::ST_RESP;
            end else begin
               state_in = bfha_pkg::ST_SHUP;
            end
         end
         bfha_pkg::ST_SHUP: begin
            if (shup_done) begin
               state_in = bfha_pkg::ST_INS_WR;
            end
         end
         bfha_pkg::ST_INS_WR: state_in = bfha_pkg::ST_RESP;
         bfha_pkg::ST_F_MARK: begin
            if (cur_idx_ff != '0) begin
               state_in = bfha_pkg::ST_F_PREV_CHK;
            end else begin
               state_in = bfha_pkg::ST_F_NEXT_RD;
            end
         end
         bfha_pkg::ST_F_PREV_CHK: begin
            if (prev_merge) begin
               state_in = bfha_pkg::ST_SHDN;
            end else begin
               state_in = bfha_pkg::ST_F_NEXT_RD;
            end
         end
         bfha_pkg::ST_F_NEXT_RD: begin
            if ((CW'(cur_idx_ff) + CW'(1)) < count_ff) begin
               state_in = bfha_pkg::ST_F_NEXT_CHK;
            end else begin
               state_in = bfha_pkg::ST_RESP;
            end
         end
         bfha_pkg::ST_F_NEXT_CHK: begin
            if (next_merge) begin
               state_in = bfha_pkg::ST_SHDN;
            end else begin
               state_in = bfha_pkg::ST_RESP;
            end
         end
         bfha_pkg::ST_SHDN: begin
            if (shdn_done) begin
               state_in = ret_next_ff ? bfha_pkg::ST_F_NEXT_RD : bfha_pkg::ST_RESP;
            end
         end
         bfha_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = bfha_pkg::ST_IDLE;
            end
         end
         default: state_in = bfha_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      header_in     = header_ff;
      limit_in      = limit_ff;
      count_in      = count_ff;
      break_in      = break_ff;
      op_in         = op_ff;
      reqsz_in      = reqsz_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_size_in  = best_size_ff;
      cur_idx_in    = cur_idx_ff;
      cur_start_in  = cur_start_ff;
      cur_size_in   = cur_size_ff;
      pos_in        = pos_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      new_in        = new_ff;
      ret_next_in   = ret_next_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      if (csr_write) begin
         if (csr_index == bfha_pkg::CSR_HEADER_BYTES) begin
            header_in = csr_wdata[6:0];
         end else begin
            limit_in = csr_wdata;
         end
      end

      case (state_ff)
         bfha_pkg::ST_IDLE: begin
            if (accept) begin
               op_in         = req_operation;
               reqsz_in      = LW'(req_request_size) & MASK_W;
               addr_in       = LW'(req_payload_address) & MASK_W;
               issue_in      = '0;
               best_vld_in   = 1'b0;
               res_grant_in  = '0;
               res_status_in = bfha_pkg::STS_OK;
            end
         end
         bfha_pkg::ST_SCAN: begin
            if (issue_ff < count_ff) begin
               ram_raddr  = issue_ff[IW-1:0];
               issue_in   = issue_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IW-1:0];
            end
            if (chk_vld_ff) begin
               if (op_ff == bfha_pkg::OP_ALLOC) begin
                  if (exact || better) begin
                     best_vld_in   = 1'b1;
                     best_idx_in   = chk_idx_ff;
                     best_start_in = rd_start;
                     best_size_in  = rd_size;
                  end
               end else if (fhit) begin
                  cur_idx_in   = chk_idx_ff;
                  cur_start_in = rd_start;
                  cur_size_in  = rd_size;
               end
            end
            if (scan_end && (op_ff == bfha_pkg::OP_FREE) && !scan_stop) begin
               res_status_in = bfha_pkg::STS_BAD_FREE;
            end
         end
         bfha_pkg::ST_A_DECIDE: begin
            if (best_vld_ff) begin
               if (split) begin
                  if (full) begin
                     res_status_in = bfha_pkg::STS_TABLE_FULL;
                  end else begin
                     ram_we       = 1'b1;
                     ram_waddr    = best_idx_ff;
                     ram_wdata    = {1'b1, keep_w[AB-1:0], best_start_ff};
                     pos_in       = CW'(best_idx_ff) + CW'(1);
                     issue_in     = count_ff;
                     new_in       = {1'b0, reqsz_ff[AB-1:0], tail_w[AB-1:0]};
                     res_grant_in = 20'((tail_w + hw) & MASK_W);
                  end
               end else begin
                  ram_we       = 1'b1;
                  ram_waddr    = best_idx_ff;
                  ram_wdata    = {1'b0, best_size_ff, best_start_ff};
                  res_grant_in = 20'((best_start_w + hw) & MASK_W);
               end
            end else if (grow_bad) begin
               res_status_in = bfha_pkg::STS_EXHAUSTED;
            end else if (full) begin
               res_status_in = bfha_pkg::STS_TABLE_FULL;
            end else begin
               pos_in       = count_ff;
               issue_in     = count_ff;
               new_in       = {1'b0, reqsz_ff[AB-1:0], break_ff[AB-1:0]};
               res_grant_in = 20'(bh_w);
               break_in     = nb_w[AB:0];
            end
         end
         bfha_pkg::ST_SHUP: begin
            // read entry j while writing the one read last cycle to j+1
            if (issue_ff > pos_ff) begin
               ram_raddr   = IW'(issue_ff - CW'(1));
               issue_in    = issue_ff - CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = IW'(issue_ff - CW'(1));
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_idx_ff + IW'(1);
               ram_wdata = ram_rdata;
            end
         end
         bfha_pkg::ST_INS_WR: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[IW-1:0];
            ram_wdata = new_ff;
            count_in  = count_ff + CW'(1);
         end
         bfha_pkg::ST_F_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = cur_idx_ff;
            ram_wdata = {1'b1, cur_size_ff, cur_start_ff};
            ram_raddr = cur_idx_ff - IW'(1);
         end
         bfha_pkg::ST_F_PREV_CHK: begin
            if (prev_merge) begin
               ram_we       = 1'b1;
               ram_waddr    = cur_idx_ff - IW'(1);
               ram_wdata    = {1'b1, AB'(rd_size_w + hw + LW'(cur_size_ff)), rd_start};
               cur_idx_in   = cur_idx_ff - IW'(1);
               cur_start_in = rd_start;
               cur_size_in  = AB'(rd_size_w + hw + LW'(cur_size_ff));
               issue_in     = CW'(cur_idx_ff) + CW'(1);
               ret_next_in  = 1'b1;
            end
         end
         bfha_pkg::ST_F_NEXT_RD: begin
            ram_raddr = cur_idx_ff + IW'(1);
         end
         bfha_pkg::ST_F_NEXT_CHK: begin
            if (next_merge) begin
               ram_we      = 1'b1;
               ram_waddr   = cur_idx_ff;
               ram_wdata   = {1'b1, AB'(LW'(cur_size_ff) + hw + rd_size_w), cur_start_ff};
               cur_size_in = AB'(LW'(cur_size_ff) + hw + rd_size_w);
               issue_in    = CW'(cur_idx_ff) + CW'(2);
               ret_next_in = 1'b0;
            end
         end
         bfha_pkg::ST_SHDN: begin
            // read entry j while writing the one read last cycle to j-1
            if (issue_ff < count_ff) begin
               ram_raddr   = issue_ff[IW-1:0];
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_idx_ff - IW'(1);
               ram_wdata = ram_rdata;
            end
            if (shdn_done) begin
               count_in = count_ff - CW'(1);
            end
         end
         bfha_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = res_grant_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfha_pkg::ST_IDLE;
         header_ff    <= bfha_pkg::HEADER_RESET;
         limit_ff     <= bfha_pkg::LIMIT_RESET;
         count_ff     <= '0;
         break_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         header_ff    <= header_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         break_ff     <= break_in;
         chk_vld_ff   <= chk_vld_in;
         best_vld_ff  <= best_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      reqsz_ff      <= reqsz_in;
      addr_ff       <= addr_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_size_ff  <= best_size_in;
      cur_idx_ff    <= cur_idx_in;
      cur_start_ff  <= cur_start_in;
      cur_size_ff   <= cur_size_in;
      pos_ff        <= pos_in;
      pend_idx_ff   <= pend_idx_in;
      new_ff        <= new_in;
      ret_next_ff   <= ret_next_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall           = (state_ff != bfha_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_status          = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SEGMENTS))
      else $error("segment count above table depth");

   a_break_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> break_ff >= $past(break_ff))
      else $error("heap break shrank");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != bfha_pkg::STS_OK) |-> rsp_grant_ff == '0)
      else $error("grant on a failed word");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfha_pkg::ST_IDLE) |-> !pend_ff)
      else $error("shift pending while idle");

endmodule
